// ===== sv/grouped_bitmap_allocator_macros.svh =====
// Assertion macros for the grouped bitmap allocator.
// Used by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef GROUPED_BITMAP_ALLOCATOR_MACROS_SVH
`define GROUPED_BITMAP_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/gba_pkg.sv =====
// Shared constants and types for the grouped bitmap allocator.
// No dependencies; imported by gba_word_scan and the top level.
package gba_pkg;

    localparam int MAX_GROUPS_DEF     = 16;
    localparam int MAX_BPG_DEF        = 8192;
    localparam int WORD_BITS_DEF      = 32;

    localparam int OPCODE_W           = 1;
    localparam int PREF_W             = 5;
    localparam int IDX_W              = 17;
    localparam int STATUS_W           = 2;
    localparam int FREE_W             = 18;
    localparam int GC_W               = 5;
    localparam int BPG_REG_W          = 14;
    localparam int CFG_ADDR_W         = 1;
    localparam int CFG_DATA_W         = 14;
    localparam int S_DATA_W           = 24;
    localparam int M_DATA_W           = 40;

    localparam logic [CFG_ADDR_W-1:0] CFG_GROUP_COUNT    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BITS_PER_GROUP = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK           = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_SPACE     = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ALREADY_FREE = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_OUT_OF_RANGE = 2'd3;

    localparam logic [GC_W-1:0]      GROUP_COUNT_RST = 5'd16;
    localparam logic [BPG_REG_W-1:0] BPG_RST         = 14'd8192;

    // Result of examining one bitmap word against the current group window.
    typedef struct packed {
        logic found;
        logic at_end;
    } scan_flags_t;

endpackage

// ===== sv/gba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the allocation bitmap.
module gba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/gba_word_scan.sv =====
// Finds the lowest clear bitmap bit of one word that lies inside a group window.
// Depends on gba_pkg for the flag struct.
module gba_word_scan
    import gba_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int ADDR_W    = 12,
    parameter int CW        = 18
) (
    input  logic [WORD_BITS-1:0]         word,
    input  logic [ADDR_W-1:0]            addr,
    input  logic [CW-1:0]                lo,
    input  logic [CW-1:0]                hi,
    output scan_flags_t                  flags,
    output logic [$clog2(WORD_BITS)-1:0] bit_sel
);

    localparam int BIT_W = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] avail;
    logic [CW-1:0]        word_end;

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            avail[i] = !word[i] && (CW'({addr, BIT_W'(i)}) >= lo)
                                && (CW'({addr, BIT_W'(i)}) < hi);
        end
    end

    always_comb
    begin
        bit_sel = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (avail[i])
            begin
                bit_sel = BIT_W'(i);
            end
        end
    end

    assign word_end     = CW'({addr, {BIT_W{1'b0}}}) + CW'(WORD_BITS);
    assign flags.found  = |avail;
    assign flags.at_end = (word_end >= hi);

endmodule

// ===== sv/grouped_bitmap_allocator.sv =====
// Top level of the grouped bitmap allocator: config registers, sequencer, counts.
// Depends on gba_pkg, gba_ram, gba_word_scan and the assertion macro header.
//
//  Channel   Direction  Handshake          Contents
//  s_*       in         s_tvalid/s_tready  request item: opcode, preference, entry index
//  m_*       out        m_tvalid/m_tready  result item: status, allocated index, free total
//  cfg_*     in         cfg_we             register writes, no read-back
//
// After reset the bitmap RAM is cleared one word per cycle and no item is taken
// meanwhile.
// An allocate takes a group-selection step per group visited in the search (and a
// final one when no group has room) and a check step per bitmap word read, all
// through the single RAM read port and the word scanner.
// A free takes one subtract step per group below the entry, then reads and checks
// the bitmap word; a free outside the active range goes straight to the result.
// A result waits in the output register, which blocks the next completion.
`include "grouped_bitmap_allocator_macros.svh"

module grouped_bitmap_allocator
    import gba_pkg::*;
#(
    parameter int MAX_GROUPS         = MAX_GROUPS_DEF,
    parameter int MAX_BITS_PER_GROUP = MAX_BPG_DEF,
    parameter int WORD_BITS          = WORD_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // preferred_group[4:0], entry_index[21:5]
    input  logic [OPCODE_W-1:0]   s_tuser,   // opcode[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // allocated_index[16:0], free_total[34:17]
    output logic [STATUS_W-1:0]   m_tuser,   // status[1:0]
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int WORD_COUNT = (MAX_GROUPS * MAX_BITS_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W     = WORD_COUNT > 1 ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int GI_W       = MAX_GROUPS > 1 ? $clog2(MAX_GROUPS) : 1;
    localparam int GN_W       = $clog2(MAX_GROUPS + 1);
    localparam int BPG_W      = $clog2(MAX_BITS_PER_GROUP + 1);
    localparam int CAP_W      = $clog2(MAX_GROUPS * MAX_BITS_PER_GROUP + 1);
    localparam int CW         = CAP_W > IDX_W ? CAP_W : IDX_W;
    localparam int BPG_TOP    = (MAX_BITS_PER_GROUP / 8) * 8;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_GSEL  = 3'd2;
    localparam logic [2:0] ST_CHK   = 3'd3;
    localparam logic [2:0] ST_FDIV  = 3'd4;
    localparam logic [2:0] ST_FRD   = 3'd5;
    localparam logic [2:0] ST_FCHK  = 3'd6;
    localparam logic [2:0] ST_RESP  = 3'd7;

    logic [GC_W-1:0]      group_count_reg;
    logic [BPG_REG_W-1:0] bpg_reg;
    logic [CW-1:0]        cap_c;
    logic [GN_W-1:0]      act_groups;
    logic [BPG_W-1:0]     act_bpg;
    logic [BPG_REG_W-1:0] bpg_even;
    logic [CW-1:0]        bpg_cw;

    logic [2:0]           state_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [GI_W-1:0]      pref_reg;
    logic                 has_pref_reg;
    logic                 try_pref_reg;
    logic [GN_W-1:0]      gidx_reg;
    logic [GI_W-1:0]      g_reg;
    logic [ADDR_W-1:0]    waddr_reg;
    logic [CW-1:0]        lo_reg;
    logic [CW-1:0]        hi_reg;
    logic [CW-1:0]        gofs_reg;
    logic [CW-1:0]        pos_reg;
    logic [CW-1:0]        rem_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic                 found_reg;
    logic [BPG_W-1:0]     used_reg [MAX_GROUPS];
    logic [CAP_W-1:0]     total_reg;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic [STATUS_W-1:0]  m_tuser_reg;

    logic                 in_opcode;
    logic [PREF_W-1:0]    in_pref;
    logic [IDX_W-1:0]     in_idx;
    logic                 in_has_pref;

    logic [GI_W-1:0]      cand_c;
    logic [CW-1:0]        base_c;
    logic                 gsel_end;
    logic                 gsel_skip_pref;
    logic                 gsel_full;
    logic                 gsel_take;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    scan_flags_t          scan_flags;
    logic [BIT_W-1:0]     scan_bit;
    logic [CW-1:0]        chk_pos_c;
    logic                 free_bit_set;
    logic [WORD_BITS-1:0] free_mask;
    logic [WORD_BITS-1:0] alloc_mask;
    logic                 resp_load;
    logic [IDX_W-1:0]     alloc_c;
    logic [FREE_W-1:0]    free_c;

    // Effective configuration: group count capped, group size rounded and clamped.
    always_comb
    begin
        if (int'(group_count_reg) > MAX_GROUPS)
        begin
            act_groups = GN_W'(MAX_GROUPS);
        end
        else
        begin
            act_groups = GN_W'(group_count_reg);
        end
        bpg_even = {bpg_reg[BPG_REG_W-1:3], 3'b000};
        if (int'(bpg_even) < 8)
        begin
            act_bpg = BPG_W'(8);
        end
        else if (int'(bpg_even) > BPG_TOP)
        begin
            act_bpg = BPG_W'(BPG_TOP);
        end
        else
        begin
            act_bpg = BPG_W'(bpg_even);
        end
    end

    assign bpg_cw = CW'(act_bpg);
    assign cap_c  = CW'(act_groups) * bpg_cw;

    assign in_opcode   = s_tuser[0];
    assign in_pref     = s_tdata[PREF_W-1:0];
    assign in_idx      = s_tdata[PREF_W+IDX_W-1:PREF_W];
    assign in_has_pref = !in_pref[PREF_W-1] && (int'(in_pref) < int'(act_groups));

    assign cand_c         = try_pref_reg ? pref_reg : GI_W'(gidx_reg);
    assign base_c         = CW'(cand_c) * CW'(MAX_BITS_PER_GROUP);
    assign gsel_end       = !try_pref_reg && (gidx_reg >= act_groups);
    assign gsel_skip_pref = !try_pref_reg && has_pref_reg && (GI_W'(gidx_reg) == pref_reg);
    assign gsel_full      = CW'(used_reg[cand_c]) >= bpg_cw;
    assign gsel_take      = !gsel_end && !gsel_skip_pref && !gsel_full;

    assign chk_pos_c    = CW'({waddr_reg, scan_bit});
    assign free_bit_set = ram_rdata[pos_reg[BIT_W-1:0]];
    assign free_mask    = {{(WORD_BITS-1){1'b0}}, 1'b1} << pos_reg[BIT_W-1:0];
    assign alloc_mask   = {{(WORD_BITS-1){1'b0}}, 1'b1} << scan_bit;

    assign resp_load = (state_reg == ST_RESP) && (!m_tvalid_reg || m_tready);
    assign alloc_c   = found_reg ? IDX_W'(gofs_reg + pos_reg - lo_reg) : '0;
    assign free_c    = (cap_c > CW'(total_reg)) ? FREE_W'(cap_c - CW'(total_reg)) : '0;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = waddr_reg;
        ram_wdata = ram_rdata | alloc_mask;
        ram_re    = 1'b0;
        ram_raddr = waddr_reg + 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
            end
            ST_GSEL:
            begin
                ram_re    = gsel_take;
                ram_raddr = ADDR_W'(base_c >> BIT_W);
            end
            ST_CHK:
            begin
                ram_we = scan_flags.found;
                ram_re = !scan_flags.found && !scan_flags.at_end;
            end
            ST_FRD:
            begin
                ram_re    = 1'b1;
                ram_raddr = ADDR_W'(pos_reg >> BIT_W);
            end
            ST_FCHK:
            begin
                ram_we    = free_bit_set;
                ram_waddr = ADDR_W'(pos_reg >> BIT_W);
                ram_wdata = ram_rdata & ~free_mask;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    gba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gba_word_scan #(
        .WORD_BITS (WORD_BITS),
        .ADDR_W    (ADDR_W),
        .CW        (CW)
    ) u_scan (
        .word    (ram_rdata),
        .addr    (waddr_reg),
        .lo      (lo_reg),
        .hi      (hi_reg),
        .flags   (scan_flags),
        .bit_sel (scan_bit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_count_reg <= GROUP_COUNT_RST;
            bpg_reg         <= BPG_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_GROUP_COUNT:    group_count_reg <= cfg_wdata[GC_W-1:0];
                    CFG_BITS_PER_GROUP: bpg_reg         <= cfg_wdata[BPG_REG_W-1:0];
                    default:            bpg_reg         <= bpg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            pref_reg     <= '0;
            has_pref_reg <= 1'b0;
            try_pref_reg <= 1'b0;
            gidx_reg     <= '0;
            g_reg        <= '0;
            waddr_reg    <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            gofs_reg     <= '0;
            pos_reg      <= '0;
            rem_reg      <= '0;
            status_reg   <= STAT_OK;
            found_reg    <= 1'b0;
            total_reg    <= '0;
            for (int i = 0; i < MAX_GROUPS; i++)
            begin
                used_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == ADDR_W'(WORD_COUNT - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        found_reg <= 1'b0;
                        if (in_opcode == OP_ALLOC)
                        begin
                            status_reg   <= STAT_OK;
                            pref_reg     <= GI_W'(in_pref);
                            has_pref_reg <= in_has_pref;
                            try_pref_reg <= in_has_pref;
                            gidx_reg     <= '0;
                            state_reg    <= ST_GSEL;
                        end
                        else if (CW'(in_idx) >= cap_c)
                        begin
                            status_reg <= STAT_OUT_OF_RANGE;
                            state_reg  <= ST_RESP;
                        end
                        else
                        begin
                            status_reg <= STAT_OK;
                            rem_reg    <= CW'(in_idx);
                            g_reg      <= '0;
                            state_reg  <= ST_FDIV;
                        end
                    end
                end
                ST_GSEL:
                begin
                    if (gsel_end)
                    begin
                        status_reg <= STAT_NO_SPACE;
                        state_reg  <= ST_RESP;
                    end
                    else if (gsel_skip_pref)
                    begin
                        gidx_reg <= gidx_reg + 1'b1;
                    end
                    else if (gsel_full)
                    begin
                        if (try_pref_reg)
                        begin
                            try_pref_reg <= 1'b0;
                        end
                        else
                        begin
                            gidx_reg <= gidx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        g_reg     <= cand_c;
                        lo_reg    <= base_c;
                        hi_reg    <= base_c + bpg_cw;
                        gofs_reg  <= CW'(cand_c) * bpg_cw;
                        waddr_reg <= ADDR_W'(base_c >> BIT_W);
                        state_reg <= ST_CHK;
                    end
                end
                ST_CHK:
                begin
                    if (scan_flags.found)
                    begin
                        used_reg[g_reg] <= used_reg[g_reg] + 1'b1;
                        total_reg       <= total_reg + 1'b1;
                        pos_reg         <= chk_pos_c;
                        found_reg       <= 1'b1;
                        state_reg       <= ST_RESP;
                    end
                    else if (scan_flags.at_end)
                    begin
                        if (try_pref_reg)
                        begin
                            try_pref_reg <= 1'b0;
                        end
                        else
                        begin
                            gidx_reg <= gidx_reg + 1'b1;
                        end
                        state_reg <= ST_GSEL;
                    end
                    else
                    begin
                        waddr_reg <= waddr_reg + 1'b1;
                    end
                end
                ST_FDIV:
                begin
                    if (rem_reg >= bpg_cw)
                    begin
                        rem_reg <= rem_reg - bpg_cw;
                        g_reg   <= g_reg + 1'b1;
                    end
                    else
                    begin
                        pos_reg   <= CW'(g_reg) * CW'(MAX_BITS_PER_GROUP) + rem_reg;
                        state_reg <= ST_FRD;
                    end
                end
                ST_FRD:
                begin
                    state_reg <= ST_FCHK;
                end
                ST_FCHK:
                begin
                    if (free_bit_set)
                    begin
                        if (used_reg[g_reg] != '0)
                        begin
                            used_reg[g_reg] <= used_reg[g_reg] - 1'b1;
                        end
                        if (total_reg != '0)
                        begin
                            total_reg <= total_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        status_reg <= STAT_ALREADY_FREE;
                    end
                    state_reg <= ST_RESP;
                end
                ST_RESP:
                begin
                    if (resp_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= STAT_OK;
        end
        else if (resp_load)
        begin
            m_tvalid_reg <= 1'b1;
            m_tdata_reg  <= {{(M_DATA_W - FREE_W - IDX_W){1'b0}}, free_c, alloc_c};
            m_tuser_reg  <= status_reg;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `GBA_ASSERT_NEXT(a_accept_starts_work, s_tvalid && s_tready, state_reg != ST_IDLE, "accepted item did not start work")
    `GBA_ASSERT_NEXT(a_resp_loads_output, resp_load, m_tvalid_reg && (state_reg == ST_IDLE), "result not loaded into output register")
    `GBA_ASSERT_SAME(a_alloc_in_group, (state_reg == ST_CHK) && scan_flags.found, (chk_pos_c >= lo_reg) && (chk_pos_c < hi_reg), "allocated bit lies outside its group")
    `GBA_ASSERT_SAME(a_total_step, 1'b1, (total_reg == $past(total_reg)) || (total_reg == $past(total_reg) + 1'b1) || (total_reg == $past(total_reg) - 1'b1), "used total moved by more than one")
    `GBA_ASSERT_SAME(a_clear_empty, state_reg == ST_CLEAR, total_reg == '0, "entries counted during clearing pass")

endmodule
